[hdl/zbni_pkg.sv]
package zbni_pkg;

  localparam int SITE_W = 20;
  localparam int CFG_W = 10;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] CELLS_RESET = 10'd8;
  localparam int MAX_CELLS_X_DEF = 512;
  localparam int MAX_CELLS_Z_DEF = 512;

  // restoring divider: site/2 divided by cells_along_x, a few quotient bits per stage
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES = (SITE_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int DIV_W = DIV_STAGES * DIV_PER_STAGE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_X = 1'b0,
    REG_CELLS_Z = 1'b1
  } cfg_reg_t;

  typedef logic [SITE_W-1:0] site_t;

  typedef struct packed {
    logic bad;
    logic odd;
    logic j_nx;
    logic k_nz;
    logic j_one;
    logic k_one;
    logic j_two;
    logic j_nxm1;
    logic k_two;
    logic k_nzm1;
  } flags_t;

  typedef struct packed {
    site_t ip1;
    site_t im1;
    site_t ip2;
    site_t im2;
    site_t ipnx;
    site_t imnx;
    site_t imnxp1;
    site_t imnxm1;
    site_t ipnxm1;
    site_t ipnxp1;
    site_t ipnxm2;
    site_t imnxp2;
    site_t ipup;
    site_t ipupp1;
    site_t ipupm1;
    site_t imup;
    site_t imupm1;
    site_t imupp1;
    site_t upp1;
    site_t upp2;
    site_t up;
    site_t tot;
    site_t nx;
    site_t nxm1;
  } terms_t;

endpackage

[hdl/zbni_if.sv]
interface zbni_site_if;
  logic valid;
  logic ready;
  logic [zbni_pkg::SITE_W-1:0] site;

  modport source (output valid, output site, input ready);
  modport sink (input valid, input site, output ready);
  modport mon (input valid, input site, input ready);
endinterface

interface zbni_nbr_if;
  logic valid;
  logic ready;
  logic [zbni_pkg::SITE_W-1:0] near_a;
  logic [zbni_pkg::SITE_W-1:0] near_b;
  logic [zbni_pkg::SITE_W-1:0] near_c;
  logic [zbni_pkg::SITE_W-1:0] near_d;
  logic [zbni_pkg::SITE_W-1:0] second_a;
  logic [zbni_pkg::SITE_W-1:0] second_b;
  logic [zbni_pkg::SITE_W-1:0] second_c;
  logic [zbni_pkg::SITE_W-1:0] second_d;
  logic bad_site;

  modport source (output valid, output near_a, output near_b, output near_c, output near_d,
                  output second_a, output second_b, output second_c, output second_d,
                  output bad_site, input ready);
  modport sink (input valid, input near_a, input near_b, input near_c, input near_d,
                input second_a, input second_b, input second_c, input second_d,
                input bad_site, output ready);
  modport mon (input valid, input near_a, input near_b, input near_c, input near_d,
               input second_a, input second_b, input second_c, input second_d,
               input bad_site, input ready);
endinterface

[hdl/zincblende_2d_neighbor_index_generator_top.sv]
// Pipeline: 9 register stages: input capture, 5 divider stages at 4 quotient bits each,
//   row/column, sum terms, output.
// Throughput: one site per clock unless rsp.ready stalls the output; each stage moves
// when it is empty or the next one moves. Reset (rst, synchronous, active high) empties
// every stage and sets both cell counts to 8; the box totals are registered from the counts.
module zincblende_2d_neighbor_index_generator_top #(
  parameter int MAX_CELLS_X = zbni_pkg::MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Z = zbni_pkg::MAX_CELLS_Z_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  zbni_site_if.sink                      req,
  zbni_nbr_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [zbni_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zbni_pkg::CFG_W-1:0]     cfg_data
);

  localparam int SW = zbni_pkg::SITE_W;
  localparam int CXW = $clog2(MAX_CELLS_X + 1);
  localparam int CZW = $clog2(MAX_CELLS_Z + 1);
  localparam int TW = CXW + CZW + 1;
  localparam int CW = (TW > SW) ? TW : SW;
  localparam int DS = zbni_pkg::DIV_STAGES;
  localparam int PER = zbni_pkg::DIV_PER_STAGE;
  localparam int DW = zbni_pkg::DIV_W;

  // configuration
  logic [zbni_pkg::CFG_W-1:0] cells_x;
  logic [zbni_pkg::CFG_W-1:0] cells_z;
  logic [CXW-1:0] cx;
  logic [CZW-1:0] cz;
  logic [CXW:0]   nx;
  logic [CZW:0]   nz;
  logic [TW-1:0]  tot;
  logic [TW-1:0]  up;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= zbni_pkg::CELLS_RESET;
      cells_z <= zbni_pkg::CELLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        zbni_pkg::REG_CELLS_X: cells_x <= cfg_data;
        zbni_pkg::REG_CELLS_Z: cells_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cells_x < 10'd2) begin
      cx = CXW'(2);
    end else if (32'(cells_x) > MAX_CELLS_X) begin
      cx = CXW'(MAX_CELLS_X);
    end else begin
      cx = CXW'(cells_x);
    end
    if (cells_z < 10'd2) begin
      cz = CZW'(2);
    end else if (32'(cells_z) > MAX_CELLS_Z) begin
      cz = CZW'(MAX_CELLS_Z);
    end else begin
      cz = CZW'(cells_z);
    end
  end

  assign nx = {cx, 1'b0};
  assign nz = {cz, 1'b0};

  always_ff @(posedge clk) begin
    tot <= (TW'(cx) * TW'(cz)) << 1;
    up  <= tot - TW'(nx);
  end

  // pipeline control
  logic [DS:0] d_valid;
  logic [DS:0] d_en;
  logic        c_valid;
  logic        c_en;
  logic        t_valid;
  logic        t_en;
  logic        o_valid;
  logic        o_en;

  assign o_en = !o_valid || rsp.ready;
  assign t_en = !t_valid || o_en;
  assign c_en = !c_valid || t_en;
  assign d_en[DS] = !d_valid[DS] || c_en;
  for (genvar s = 0; s < DS; s++) begin : g_en
    assign d_en[s] = !d_valid[s] || d_en[s+1];
  end
  assign req.ready = d_en[0];

  // input capture
  zbni_pkg::site_t d_site [0:DS];
  logic [CXW-1:0]  d_rem  [1:DS];
  logic [DW-1:0]   d_quo  [1:DS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (d_en[0]) begin
      d_valid[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en[0]) begin
      d_site[0] <= req.site;
    end
  end

  // divider stages: (site >> 1) / cx, remainder kept for the column
  for (genvar s = 1; s <= DS; s++) begin : g_div
    logic [CXW-1:0] rem_next;
    logic [DW-1:0]  quo_next;

    always_comb begin
      logic [CXW:0]  trial;
      logic [DW-1:0] dvd;
      dvd = DW'(d_site[s-1] >> 1);
      if (s == 1) begin
        rem_next = '0;
        quo_next = '0;
      end else begin
        rem_next = d_rem[(s == 1) ? 1 : s-1];
        quo_next = d_quo[(s == 1) ? 1 : s-1];
      end
      for (int t = 0; t < PER; t++) begin
        trial = {rem_next, dvd[DW-1-((s-1)*PER+t)]};
        if (trial >= {1'b0, cx}) begin
          rem_next = CXW'(trial - {1'b0, cx});
          quo_next = {quo_next[DW-2:0], 1'b1};
        end else begin
          rem_next = trial[CXW-1:0];
          quo_next = {quo_next[DW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[s] <= 1'b0;
      end else if (d_en[s]) begin
        d_valid[s] <= d_valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (d_en[s]) begin
        d_site[s] <= d_site[s-1];
        d_rem[s]  <= rem_next;
        d_quo[s]  <= quo_next;
      end
    end
  end

  // column and row
  zbni_pkg::site_t c_site;
  logic [CXW:0]    c_j;
  zbni_pkg::site_t c_k;
  logic            c_bad;
  logic [CXW:0]    j_raw;
  logic [CXW:0]    j_next;
  zbni_pkg::site_t k_next;
  logic [DW-1:0]   n_even;
  logic            bad_next;

  always_comb begin
    j_raw = {d_rem[DS], d_site[DS][0]};
    j_next = (j_raw == '0) ? nx : j_raw;
    n_even = (j_raw == '0) ? d_quo[DS] : d_quo[DS] + DW'(1);
    if (d_site[DS][0]) begin
      k_next = {d_quo[DS][SW-2:0], 1'b1};
    end else begin
      k_next = {n_even[SW-2:0], 1'b0};
    end
    bad_next = (d_site[DS] == '0) || (CW'(d_site[DS]) > CW'(tot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_en) begin
      c_valid <= d_valid[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_site <= d_site[DS];
      c_j    <= j_next;
      c_k    <= k_next;
      c_bad  <= bad_next;
    end
  end

  // edge flags and candidate sums
  zbni_pkg::flags_t flags;
  zbni_pkg::flags_t flags_next;
  zbni_pkg::terms_t terms;
  zbni_pkg::terms_t terms_next;
  zbni_pkg::site_t  nx_s;
  zbni_pkg::site_t  nz_s;
  zbni_pkg::site_t  up_s;
  zbni_pkg::site_t  tot_s;

  assign nx_s  = SW'(nx);
  assign nz_s  = SW'(nz);
  assign up_s  = SW'(up);
  assign tot_s = SW'(tot);

  always_comb begin
    flags_next.bad    = c_bad;
    flags_next.odd    = c_site[0];
    flags_next.j_nx   = (c_j == nx);
    flags_next.k_nz   = (c_k == nz_s);
    flags_next.j_one  = (c_j == (CXW+1)'(1));
    flags_next.k_one  = (c_k == SW'(1));
    flags_next.j_two  = (c_j == (CXW+1)'(2));
    flags_next.j_nxm1 = (c_j == nx - (CXW+1)'(1));
    flags_next.k_two  = (c_k == SW'(2));
    flags_next.k_nzm1 = (c_k == nz_s - SW'(1));

    terms_next.ip1    = c_site + SW'(1);
    terms_next.im1    = c_site - SW'(1);
    terms_next.ip2    = c_site + SW'(2);
    terms_next.im2    = c_site - SW'(2);
    terms_next.ipnx   = c_site + nx_s;
    terms_next.imnx   = c_site - nx_s;
    terms_next.imnxp1 = c_site - nx_s + SW'(1);
    terms_next.imnxm1 = c_site - nx_s - SW'(1);
    terms_next.ipnxm1 = c_site + nx_s - SW'(1);
    terms_next.ipnxp1 = c_site + nx_s + SW'(1);
    terms_next.ipnxm2 = c_site + nx_s - SW'(2);
    terms_next.imnxp2 = c_site - nx_s + SW'(2);
    terms_next.ipup   = c_site + up_s;
    terms_next.ipupp1 = c_site + up_s + SW'(1);
    terms_next.ipupm1 = c_site + up_s - SW'(1);
    terms_next.imup   = c_site - up_s;
    terms_next.imupm1 = c_site - up_s - SW'(1);
    terms_next.imupp1 = c_site - up_s + SW'(1);
    terms_next.upp1   = up_s + SW'(1);
    terms_next.upp2   = up_s + SW'(2);
    terms_next.up     = up_s;
    terms_next.tot    = tot_s;
    terms_next.nx     = nx_s;
    terms_next.nxm1   = nx_s - SW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (t_en) begin
      t_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (t_en) begin
      flags <= flags_next;
      terms <= terms_next;
    end
  end

  // rule selection; earlier rules take priority, corners first
  zbni_pkg::site_t r0, r1, r2, r3, r4, r5, r6, r7;
  zbni_pkg::site_t o0, o1, o2, o3, o4, o5, o6, o7;
  logic            o_bad;

  always_comb begin
    if (flags.j_nx && flags.k_nz) begin
      r0 = terms.upp1;   r1 = terms.im1;    r2 = terms.nxm1;   r3 = SW'(1);
      r4 = terms.upp2;   r5 = terms.up;     r6 = terms.im2;    r7 = terms.nx;
    end else if (flags.j_one && flags.k_one) begin
      r0 = terms.upp2;   r1 = terms.tot;    r2 = terms.nx;     r3 = SW'(2);
      r4 = terms.ip2;    r5 = terms.upp1;   r6 = terms.nxm1;   r7 = terms.ipnx;
    end else if (flags.j_nx) begin
      r0 = terms.imnxp1; r1 = terms.im1;    r2 = terms.ipnxm1; r3 = terms.ip1;
      r4 = terms.imnxp2;
      r5 = flags.k_two ? terms.tot : terms.imnx;
      r6 = terms.im2;    r7 = terms.ipnx;
    end else if (flags.k_nz) begin
      r0 = terms.ip1;    r1 = terms.im1;    r2 = terms.imupm1; r3 = terms.imupp1;
      r4 = terms.ip2;    r5 = terms.imnx;
      r6 = flags.j_two ? terms.tot : terms.im2;
      r7 = terms.imup;
    end else if (flags.k_one && !flags.j_one) begin
      r0 = terms.ipupp1; r1 = terms.ipupm1; r2 = terms.im1;    r3 = terms.ip1;
      r4 = flags.j_nxm1 ? SW'(1) : terms.ip2;
      r5 = terms.ipup;   r6 = terms.im2;    r7 = terms.ipnx;
    end else if (flags.j_one) begin
      r0 = terms.imnxp1; r1 = terms.im1;    r2 = terms.ipnxm1; r3 = terms.ip1;
      r4 = terms.ip2;    r5 = terms.imnx;   r6 = terms.ipnxm2;
      r7 = flags.k_nzm1 ? SW'(1) : terms.ipnx;
    end else begin
      if (flags.odd) begin
        r0 = terms.imnxp1; r1 = terms.imnxm1; r2 = terms.im1;    r3 = terms.ip1;
      end else begin
        r0 = terms.ip1;    r1 = terms.im1;    r2 = terms.ipnxm1; r3 = terms.ipnxp1;
      end
      r4 = flags.j_nxm1 ? terms.imnxp2 : terms.ip2;
      r5 = flags.k_two  ? terms.ipup   : terms.imnx;
      r6 = flags.j_two  ? terms.ipnxm2 : terms.im2;
      r7 = flags.k_nzm1 ? terms.imup   : terms.ipnx;
    end
    if (flags.bad) begin
      r0 = '0; r1 = '0; r2 = '0; r3 = '0;
      r4 = '0; r5 = '0; r6 = '0; r7 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_en) begin
      o_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      o0 <= r0; o1 <= r1; o2 <= r2; o3 <= r3;
      o4 <= r4; o5 <= r5; o6 <= r6; o7 <= r7;
      o_bad <= flags.bad;
    end
  end

  assign rsp.valid    = o_valid;
  assign rsp.near_a   = o0;
  assign rsp.near_b   = o1;
  assign rsp.near_c   = o2;
  assign rsp.near_d   = o3;
  assign rsp.second_a = o4;
  assign rsp.second_b = o5;
  assign rsp.second_c = o6;
  assign rsp.second_d = o7;
  assign rsp.bad_site = o_bad;

endmodule

[hdl/zbni_check.sv]
module zbni_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [zbni_pkg::SITE_W-1:0] near_a,
  input logic [zbni_pkg::SITE_W-1:0] near_b,
  input logic [zbni_pkg::SITE_W-1:0] near_c,
  input logic [zbni_pkg::SITE_W-1:0] near_d,
  input logic [zbni_pkg::SITE_W-1:0] second_a,
  input logic [zbni_pkg::SITE_W-1:0] second_b,
  input logic [zbni_pkg::SITE_W-1:0] second_c,
  input logic [zbni_pkg::SITE_W-1:0] second_d,
  input logic                        bad_site
);

  // a held result transaction keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(near_a) && $stable(near_b)
      && $stable(near_c) && $stable(near_d) && $stable(second_a)
      && $stable(second_b) && $stable(second_c) && $stable(second_d)
      && $stable(bad_site))
    else $error("result changed while stalled");

  // out-of-range site carries no neighbors
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bad_site |-> near_a == '0 && near_b == '0 && near_c == '0
      && near_d == '0 && second_a == '0 && second_b == '0
      && second_c == '0 && second_d == '0)
    else $error("bad site with nonzero neighbor");

  // pipeline only backs up into the input once the output holds a result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind zincblende_2d_neighbor_index_generator_top zbni_check u_zbni_check (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .near_a(rsp.near_a),
  .near_b(rsp.near_b),
  .near_c(rsp.near_c),
  .near_d(rsp.near_d),
  .second_a(rsp.second_a),
  .second_b(rsp.second_b),
  .second_c(rsp.second_c),
  .second_d(rsp.second_d),
  .bad_site(rsp.bad_site)
);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT_CYCLES = 300000;
  localparam int N_SETTINGS = 10;
  localparam int SITES_PER_SETTING = 200;
  localparam int CHUNK = 40;

  typedef struct packed {
    logic bad;
    zbni_pkg::site_t [0:7] nbr;
  } hood_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [zbni_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [zbni_pkg::CFG_W-1:0] cfg_data;

  zbni_site_if req_if ();
  zbni_nbr_if rsp_if ();

  zincblende_2d_neighbor_index_generator_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // register copies used by the predictor
  logic [zbni_pkg::CFG_W-1:0] cells_x_reg;
  logic [zbni_pkg::CFG_W-1:0] cells_z_reg;

  zbni_pkg::site_t pending_sites[$];
  hood_t expected_hoods[$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors = 0;
  int results_checked = 0;
  int bad_results = 0;
  int sites_sent = 0;
  int cycles = 0;

  string field_names [8] = '{"near_a", "near_b", "near_c", "near_d",
                             "second_a", "second_b", "second_c", "second_d"};

  logic [zbni_pkg::CFG_W-1:0] cx_list [N_SETTINGS] = '{10'd2, 10'd512, 10'd0, 10'd1, 10'd1023,
                                                      10'd5, 10'd512, 10'd2, 10'd3, 10'd7};
  logic [zbni_pkg::CFG_W-1:0] cz_list [N_SETTINGS] = '{10'd2, 10'd512, 10'd1023, 10'd7, 10'd0,
                                                      10'd3, 10'd2, 10'd512, 10'd4, 10'd6};

  zbni_pkg::site_t directed_sites [25] = '{
    20'd0, 20'd1, 20'd2, 20'd3, 20'd14, 20'd15, 20'd16, 20'd17, 20'd18, 20'd31,
    20'd32, 20'd33, 20'd34, 20'd50, 20'd51, 20'd111, 20'd112, 20'd113, 20'd114, 20'd126,
    20'd127, 20'd128, 20'd129, 20'hFFFFF, 20'd524288
  };

  function automatic int unsigned clamp_cells(logic [zbni_pkg::CFG_W-1:0] v,
                                              int unsigned hi);
    if (32'(v) < 2)
      return 2;
    if (32'(v) > hi)
      return hi;
    return 32'(v);
  endfunction

  function automatic hood_t neighbors_of(zbni_pkg::site_t s);
    int unsigned cx, cz, nx, nz, tot, up, i, j, k, n;
    int unsigned r [8];
    hood_t h;
    cx = clamp_cells(cells_x_reg, zbni_pkg::MAX_CELLS_X_DEF);
    cz = clamp_cells(cells_z_reg, zbni_pkg::MAX_CELLS_Z_DEF);
    nx = 2 * cx;
    nz = 2 * cz;
    tot = 2 * cx * cz;
    up = tot - nx;
    i = 32'(s);
    h = '0;
    if (i == 0 || i > tot) begin
      h.bad = 1'b1;
      return h;
    end
    j = i % nx;
    if (j == 0)
      j = nx;
    if (i % 2 == 1) begin
      k = 2 * (i / nx) + 1;
    end else begin
      n = (i % nx == 0) ? i / nx : i / nx + 1;
      k = 2 * n;
    end

    if (j == nx && k == nz) begin
      // bottom-right corner
      r = '{up + 1, i - 1, nx - 1, 1, up + 2, up, i - 2, nx};
    end else if (j == 1 && k == 1) begin
      // top-left corner
      r = '{up + 2, tot, nx, 2, i + 2, up + 1, nx - 1, i + nx};
    end else if (j == nx) begin
      r = '{i - nx + 1, i - 1, i + nx - 1, i + 1, i - nx + 2,
            (k == 2) ? tot : i - nx, i - 2, i + nx};
    end else if (k == nz) begin
      r = '{i + 1, i - 1, i - up - 1, i - up + 1, i + 2, i - nx,
            (j == 2) ? tot : i - 2, i - up};
    end else if (k == 1) begin
      r = '{i + up + 1, i + up - 1, i - 1, i + 1, (j == nx - 1) ? 1 : i + 2,
            i + up, i - 2, i + nx};
    end else if (j == 1) begin
      r = '{i - nx + 1, i - 1, i + nx - 1, i + 1, i + 2, i - nx, i + nx - 2,
            (k == nz - 1) ? 1 : i + nx};
    end else begin
      if (i % 2 == 1) begin
        r[0] = i - nx + 1; r[1] = i - nx - 1; r[2] = i - 1; r[3] = i + 1;
      end else begin
        r[0] = i + 1; r[1] = i - 1; r[2] = i + nx - 1; r[3] = i + nx + 1;
      end
      r[4] = (j == nx - 1) ? i - nx + 2 : i + 2;
      r[5] = (k == 2) ? up + i : i - nx;
      r[6] = (j == 2) ? i + nx - 2 : i - 2;
      r[7] = (k == nz - 1) ? i - up : i + nx;
    end
    for (int q = 0; q < 8; q++)
      h.nbr[q] = zbni_pkg::site_t'(r[q]);
    return h;
  endfunction

  // mix of near-row-boundary sites (edges, corners), any valid site, out of range and raw noise
  function automatic zbni_pkg::site_t pick_site();
    int unsigned cx, cz, nx, tot, sel;
    int v;
    cx = clamp_cells(cells_x_reg, zbni_pkg::MAX_CELLS_X_DEF);
    cz = clamp_cells(cells_z_reg, zbni_pkg::MAX_CELLS_Z_DEF);
    nx = 2 * cx;
    tot = 2 * cx * cz;
    sel = $urandom_range(0, 99);
    if (sel < 8)
      return zbni_pkg::site_t'($urandom());
    if (sel < 14)
      return (sel < 9) ? '0 : zbni_pkg::site_t'(tot + $urandom_range(1, 4));
    if (sel < 60) begin
      v = int'($urandom_range(0, cz) * nx + $urandom_range(0, 6) - 3);
      if (v < 1)
        v = 1;
      if (v > int'(tot))
        v = int'(tot);
      return zbni_pkg::site_t'(v);
    end
    return zbni_pkg::site_t'($urandom_range(1, tot));
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic wait_drained();
    while (pending_sites.size() != 0 || req_if.valid || expected_hoods.size() != 0)
      @(posedge clk);
    // pipeline is 9 stages deep
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cells(zbni_pkg::cfg_reg_t idx, logic [zbni_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == zbni_pkg::REG_CELLS_X)
      cells_x_reg = v;
    else
      cells_z_reg = v;
  endtask

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("zincblende_2d_neighbor_index_generator_top: mismatch");
      $finish;
    end
  end

  // driver: holds a site until its transaction completes
  always @(posedge clk) begin
    logic launch;
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.site <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        expected_hoods.push_back(neighbors_of(req_if.site));
        sites_sent++;
      end
      launch = (pending_sites.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
      if (launch)
        req_if.site <= pending_sites.pop_front();
      req_if.valid <= launch;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    hood_t got, want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.bad = rsp_if.bad_site;
        got.nbr[0] = rsp_if.near_a;
        got.nbr[1] = rsp_if.near_b;
        got.nbr[2] = rsp_if.near_c;
        got.nbr[3] = rsp_if.near_d;
        got.nbr[4] = rsp_if.second_a;
        got.nbr[5] = rsp_if.second_b;
        got.nbr[6] = rsp_if.second_c;
        got.nbr[7] = rsp_if.second_d;
        if (expected_hoods.size() == 0) begin
          report_mismatch("result with nothing outstanding, near_a", 32'(got.nbr[0]), 0);
        end else begin
          want = expected_hoods.pop_front();
          results_checked++;
          if (want.bad)
            bad_results++;
          if (got.bad !== want.bad)
            report_mismatch("bad_site", 32'(got.bad), 32'(want.bad));
          for (int q = 0; q < 8; q++)
            if (got.nbr[q] !== want.nbr[q])
              report_mismatch(field_names[q], 32'(got.nbr[q]), 32'(want.nbr[q]));
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int pushed;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = zbni_pkg::REG_CELLS_X;
    cfg_data = '0;
    cells_x_reg = zbni_pkg::CELLS_RESET;
    cells_z_reg = zbni_pkg::CELLS_RESET;
    pushed = 0;
    send_idle_pct = 28;
    recv_idle_pct = 77;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // directed sites on the reset geometry (nx = nz = 16, 128 sites)
    foreach (directed_sites[d])
      pending_sites.push_back(directed_sites[d]);
    pushed += 25;

    for (int c = 0; c < N_SETTINGS; c++) begin
      wait_drained();
      write_cells(zbni_pkg::REG_CELLS_X, cx_list[c]);
      write_cells(zbni_pkg::REG_CELLS_Z, cz_list[c]);
      @(posedge clk);
      cfg_we <= 1'b0;
      // box totals are registered from the cell counts, up from tot
      repeat (4) @(posedge clk);
      for (int b = 0; b < SITES_PER_SETTING; b += CHUNK) begin
        while (pending_sites.size() != 0)
          @(posedge clk);
        if (pushed < 675) begin
          send_idle_pct = 28;
          recv_idle_pct = 77;
        end else if (pushed < 1350) begin
          send_idle_pct = 77;
          recv_idle_pct = 28;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        for (int s = 0; s < CHUNK; s++)
          pending_sites.push_back(pick_site());
        pushed += CHUNK;
      end
    end

    wait_drained();
    $display("sent %0d sites over %0d cell-count settings plus the reset geometry",
             sites_sent, N_SETTINGS);
    $display("checked %0d neighbor sets, %0d of them flagged as bad sites, %0d errors",
             results_checked, bad_results, errors);
    if (errors == 0)
      $display("zincblende_2d_neighbor_index_generator_top: match");
    else
      $display("zincblende_2d_neighbor_index_generator_top: mismatch");
    $finish;
  end

endmodule

[filelist.f]
hdl/zbni_pkg.sv
hdl/zbni_if.sv
hdl/zincblende_2d_neighbor_index_generator_top.sv
hdl/zbni_check.sv
tb/testbench.sv
